[rtl/bls_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants of the bounded LIFO stack
// Request and result layouts, request and status codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int WORD_BITS_DEF = 32;
    localparam int CAP_BITS      = 9;
    localparam int POS_BITS      = 8;
    localparam int DATA_BITS     = 32;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 9'd256;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_PEEK   = 2'd2,
        REQ_CHANGE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        t_req                        req_type;
        logic signed [DATA_BITS-1:0] data;
        logic [POS_BITS-1:0]         position;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] value;
        t_status                     status;
        logic [CAP_BITS-1:0]         elements;
        logic                        is_empty;
        logic                        is_full;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic clear;    // write zero at the sweep address
        logic accept;   // take the request on the input port
        logic capture;  // load the read word into the result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic need_read;
    } t_dp_sts;

    // capacity saturated to 1..depth
    function automatic logic [CAP_BITS-1:0] eff_cap(input logic [CAP_BITS-1:0] cap,
                                                    input int depth);
        logic [CAP_BITS-1:0] res;
        res = cap;
        if (cap == '0) begin
            res = CAP_BITS'(1);
        end else if (int'(cap) > depth) begin
            res = CAP_BITS'(depth);
        end
        return res;
    endfunction

endpackage

[rtl/bls_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_ctrl: request sequencer of the bounded LIFO stack
// Runs the store clearing sweep after reset, then takes one request at a
// time, waits on the store read where one is needed and holds the result.
// ----------------------------------------------------------------------------
module bls_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  bls_pkg::t_dp_sts i_sts,
    output bls_pkg::t_dp_cmd o_cmd
);
    import bls_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = i_sts.need_read ? S_READ : S_OUT;
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_cmd.clear   = (r_state == S_CLEAR);
    assign o_cmd.accept  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.capture = (r_state == S_READ);

    a_capture_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> $past(o_cmd.accept) && $past(i_sts.need_read))
        else $error("capture without a preceding read request");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> !o_out_valid && !o_cmd.clear)
        else $error("request taken while a result or the sweep is pending");

endmodule

[rtl/bls_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_dpath: store and pointer datapath of the bounded LIFO stack
// Slot memory with registered read, element count, effective capacity,
// request decode and the result register.
// ----------------------------------------------------------------------------
module bls_dpath #(
    parameter int DEPTH     = bls_pkg::DEPTH_DEF,
    parameter int WORD_BITS = bls_pkg::WORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bls_pkg::t_dp_cmd                 i_cmd,
    output bls_pkg::t_dp_sts                 o_sts,
    input  bls_pkg::t_in_item                i_item,
    input  logic                             i_cfg_we,
    input  logic [bls_pkg::CAP_BITS-1:0]     i_cfg_data,
    output bls_pkg::t_out_item               o_item
);
    import bls_pkg::*;

    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int IW = (AW > CAP_BITS) ? AW : CAP_BITS;
    localparam int PW = (AW > POS_BITS) ? AW : POS_BITS;
    localparam int XW = (WORD_BITS > DATA_BITS) ? WORD_BITS : DATA_BITS;
    localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [WORD_BITS-1:0] WORD_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [XW-1:0]        WORD_MIN_X = XW'(WORD_MIN);
    localparam logic [CAP_BITS-1:0]  EFF_RESET = eff_cap(CAP_RESET, DEPTH);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;
    logic [AW-1:0]        r_clr, n_clr;
    logic [CAP_BITS-1:0]  r_count, n_count;
    logic [CAP_BITS-1:0]  r_eff, n_eff;
    t_out_item            r_res, n_res;

    logic [CAP_BITS-1:0]  w_cnt_m1;
    logic [IW-1:0]        w_cnt_x, w_cnt_m1_x;
    logic [PW-1:0]        w_pos_x;
    logic [AW-1:0]        w_idx_cnt, w_idx_top, w_idx_pos;
    logic [XW-1:0]        w_data_x, w_rdata_x;
    logic [WORD_BITS-1:0] w_word;
    logic                 w_pos_out;
    logic                 w_we, w_rd;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [CAP_BITS-1:0]  w_cnt_new, w_eff_cfg;
    t_status              w_status;
    logic [XW-1:0]        w_value_x;

    // indexes: all in range by construction, count <= cap <= DEPTH
    assign w_cnt_m1   = r_count - CAP_BITS'(1);
    assign w_cnt_x    = IW'(r_count);
    assign w_cnt_m1_x = IW'(w_cnt_m1);
    assign w_pos_x    = PW'(i_item.position);
    assign w_idx_cnt  = w_cnt_x[AW-1:0];
    assign w_idx_top  = w_cnt_m1_x[AW-1:0];
    assign w_idx_pos  = w_pos_x[AW-1:0];

    assign w_data_x  = XW'(i_item.data);
    assign w_word    = w_data_x[WORD_BITS-1:0];
    assign w_rdata_x = XW'(r_rdata);
    assign w_pos_out = ({1'b0, i_item.position} >= r_eff);
    assign w_eff_cfg = eff_cap(i_cfg_data, DEPTH);

    always_comb begin
        w_we      = 1'b0;
        w_rd      = 1'b0;
        w_waddr   = w_idx_cnt;
        w_raddr   = w_idx_top;
        w_cnt_new = r_count;
        w_status  = ST_OK;
        w_value_x = '0;
        case (i_item.req_type)
            REQ_PUSH: begin
                if (r_count >= r_eff) begin
                    w_status = ST_OVER;
                end else begin
                    w_we      = 1'b1;
                    w_cnt_new = r_count + CAP_BITS'(1);
                end
            end
            REQ_POP: begin
                if (r_count == '0) begin
                    w_status  = ST_UNDER;
                    w_value_x = WORD_MIN_X;
                end else begin
                    w_rd      = 1'b1;
                    w_cnt_new = w_cnt_m1;
                end
            end
            REQ_PEEK: begin
                if (r_count == '0) begin
                    w_status  = ST_UNDER;
                    w_value_x = WORD_MIN_X;
                end else if (w_pos_out) begin
                    w_status = ST_RANGE;
                end else begin
                    w_rd    = 1'b1;
                    w_raddr = w_idx_pos;
                end
            end
            REQ_CHANGE: begin
                if (w_pos_out) begin
                    w_status = ST_RANGE;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_idx_pos;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    assign o_sts.need_read  = w_rd;
    assign o_sts.clear_last = (r_clr == LAST_ADDR);

    // slot memory: one write port (sweep or request), one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_clr] <= '0;
        end else if (i_cmd.accept && w_we) begin
            r_mem[w_waddr] <= w_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_rd) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_comb begin
        n_clr   = r_clr;
        n_count = r_count;
        n_eff   = r_eff;
        n_res   = r_res;
        if (i_cmd.clear) begin
            n_clr = r_clr + AW'(1);
        end
        if (i_cmd.accept) begin
            n_count        = w_cnt_new;
            n_res.value    = w_value_x[DATA_BITS-1:0];
            n_res.status   = w_status;
            n_res.elements = w_cnt_new;
            n_res.is_empty = (w_cnt_new == '0);
            n_res.is_full  = (w_cnt_new == r_eff);
        end
        // a capacity write on the same edge as a request lands after it
        if (i_cfg_we) begin
            n_eff = w_eff_cfg;
            if (n_count > w_eff_cfg) n_count = w_eff_cfg;
        end
        if (i_cmd.capture) begin
            n_res.value = w_rdata_x[DATA_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_count <= '0;
            r_eff   <= EFF_RESET;
        end else begin
            r_clr   <= n_clr;
            r_count <= n_count;
            r_eff   <= n_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_item = r_res;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= r_eff) && (r_eff != '0))
        else $error("element count above effective capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && !i_cfg_we && (i_item.req_type == REQ_PUSH) && (r_count < r_eff)
        |=> r_count == $past(r_count) + CAP_BITS'(1))
        else $error("accepted push did not raise the count");

endmodule

[rtl/bounded_lifo_stack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_lifo_stack: LIFO stack with configurable capacity
// Push, pop, peek at position and change at position over a slot memory.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in      | request   | i_in_valid/o_in_stall   | t_in_item
//   out     | result    | o_out_valid/i_out_stall | t_out_item
//   cfg     | write     | i_cfg_valid/o_cfg_ready | capacity, 9 bits
//
// One request at a time: push, change and fault results go from acceptance
// to the result state, pop and peek through a read state first (registered
// memory read). After reset a sweep zeroes the store, one slot a cycle, with
// the input stalled. Configuration writes are taken at any time.
// A stalled result holds the block; the input stays stalled until it leaves.
// ----------------------------------------------------------------------------
module bounded_lifo_stack #(
    parameter int DEPTH     = bls_pkg::DEPTH_DEF,
    parameter int WORD_BITS = bls_pkg::WORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  bls_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output bls_pkg::t_out_item           o_out_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bls_pkg::CAP_BITS-1:0] i_cfg_data
);
    import bls_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    bls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bls_dpath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_item     (o_out_item)
    );

endmodule
